@@ rtl/core/tksc_pkg.sv @@
// Shared types, constants and codes for the three-key scanner.
`default_nettype none

package tksc_pkg;

    localparam int KEY_COUNT   = 3;
    localparam int HOLD_W      = 10;
    localparam int LEVEL_W     = 8;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 2;

    localparam logic [HOLD_W-1:0]  HOLD_CAP        = 10'd600;
    localparam logic [HOLD_W-1:0]  HOLD_LIMIT_RST  = 10'd500;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL_RST  = 8'd255;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LED_MODE   = 2'd0,
        REG_FULL_LEVEL = 2'd1,
        REG_HOLD_LIMIT = 2'd2
    } reg_index_t;

    // LED modes
    localparam logic [1:0] LED_MODE_NONE      = 2'd0;
    localparam logic [1:0] LED_MODE_OFTEN_ON  = 2'd1;
    localparam logic [1:0] LED_MODE_OFTEN_OFF = 2'd2;

    // LED commands
    localparam logic [1:0] LED_CMD_NONE = 2'd0;
    localparam logic [1:0] LED_CMD_SET  = 2'd1;
    localparam logic [1:0] LED_CMD_RAMP = 2'd2;

    // Chord events
    localparam logic [1:0] CHORD_NONE       = 2'd0;
    localparam logic [1:0] CHORD_KEY3_MODE  = 2'd1;
    localparam logic [1:0] CHORD_KEY12_MODE = 2'd2;
    localparam logic [1:0] CHORD_BACKGROUND = 2'd3;

    typedef struct packed {
        logic [1:0]         led_mode;
        logic [LEVEL_W-1:0] full_level;
        logic [HOLD_W-1:0]  hold_limit;
    } cfg_t;

    typedef struct packed {
        logic [KEY_COUNT-1:0]             down;
        logic [KEY_COUNT-1:0][HOLD_W-1:0] hold;
        logic [1:0]                       last;
    } key_state_t;

    typedef struct packed {
        logic               changed;
        logic [2:0]         pressed_mask;
        logic [1:0]         last_key;
        logic [1:0]         new_presses;
        logic [1:0]         led0_cmd;
        logic [LEVEL_W-1:0] led0_level;
        logic [1:0]         led1_cmd;
        logic [LEVEL_W-1:0] led1_level;
        logic [1:0]         chord_event;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/tksc_if.sv @@
// Stream interfaces for key samples and scan results.
`default_nettype none

interface tksc_sample_if;
    logic       valid;
    logic       ready;
    logic [2:0] key_pins;

    modport source (output valid, output key_pins, input ready);
    modport sink (input valid, input key_pins, output ready);
endinterface

interface tksc_result_if;
    logic       valid;
    logic       ready;
    logic       changed;
    logic [2:0] pressed_mask;
    logic [1:0] last_key;
    logic [1:0] new_presses;
    logic [1:0] led0_cmd;
    logic [7:0] led0_level;
    logic [1:0] led1_cmd;
    logic [7:0] led1_level;
    logic [1:0] chord_event;

    modport source (
        output valid, output changed, output pressed_mask, output last_key,
        output new_presses, output led0_cmd, output led0_level, output led1_cmd,
        output led1_level, output chord_event, input ready
    );
    modport sink (
        input valid, input changed, input pressed_mask, input last_key,
        input new_presses, input led0_cmd, input led0_level, input led1_cmd,
        input led1_level, input chord_event, output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/tksc_step.sv @@
// Per-tick key update: next key state and result for one sample.
`default_nettype none

module tksc_step
    import tksc_pkg::*;
(
    input  cfg_t                 cfg,
    input  key_state_t           cur,
    input  logic [KEY_COUNT-1:0] key_pins,
    output key_state_t           nxt,
    output result_t              res
);

    always_comb
    begin
        key_state_t                    s;
        logic                          changed;
        logic [1:0]                    presses;
        logic [1:0]                    chord;
        logic [1:0]                    ev;
        logic [1:0][1:0]               cmd;
        logic [1:0][LEVEL_W-1:0]       lvl;
        logic [HOLD_W-1:0]             cnt;
        logic                          pressed;

        s       = cur;
        changed = 1'b0;
        presses = 2'd0;
        chord   = CHORD_NONE;
        cmd     = '0;
        lvl     = '0;
        ev      = CHORD_NONE;
        cnt     = '0;
        pressed = 1'b0;

        // Keys are handled in order; later keys see earlier updates.
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            pressed = !key_pins[i];
            ev      = CHORD_NONE;
            cnt     = s.hold[i];
            if (!s.down[i])
            begin
                if (pressed)
                begin
                    s.down[i] = 1'b1;
                    changed   = 1'b1;
                    presses   = presses + 2'd1;
                    s.last    = 2'(i);
                    if (i <= 1)
                    begin
                        if (cfg.led_mode == LED_MODE_OFTEN_ON)
                        begin
                            cmd[i] = LED_CMD_SET;
                            lvl[i] = '0;
                        end
                        else if (cfg.led_mode == LED_MODE_OFTEN_OFF)
                        begin
                            cmd[i] = LED_CMD_SET;
                            lvl[i] = cfg.full_level;
                        end
                    end
                end
            end
            else if (!pressed)
            begin
                if (i <= 1)
                begin
                    if (cfg.led_mode == LED_MODE_OFTEN_ON)
                    begin
                        cmd[i] = LED_CMD_RAMP;
                        lvl[i] = cfg.full_level;
                    end
                    else if (cfg.led_mode == LED_MODE_OFTEN_OFF)
                    begin
                        cmd[i] = LED_CMD_RAMP;
                        lvl[i] = '0;
                    end
                end
                s.down[i] = 1'b0;
                changed   = 1'b1;
                s.hold[i] = '0;
            end
            else
            begin
                // Held: saturate at the cap, wrap past the limit and check the chord.
                if (cnt < HOLD_CAP)
                begin
                    cnt = cnt + 10'd1;
                end
                if (cnt > cfg.hold_limit)
                begin
                    cnt = '0;
                    if (s.down == 3'b111 && s.last == 2'(i))
                    begin
                        case (i)
                            0:       ev = CHORD_KEY12_MODE;
                            1:       ev = CHORD_BACKGROUND;
                            default: ev = CHORD_KEY3_MODE;
                        endcase
                    end
                    if (chord == CHORD_NONE)
                    begin
                        chord = ev;
                    end
                end
                s.hold[i] = cnt;
            end
        end

        nxt              = s;
        res.changed      = changed;
        res.pressed_mask = s.down;
        res.last_key     = s.last;
        res.new_presses  = presses;
        res.led0_cmd     = cmd[0];
        res.led0_level   = lvl[0];
        res.led1_cmd     = cmd[1];
        res.led1_level   = lvl[1];
        res.chord_event  = chord;
    end

endmodule

`default_nettype wire

@@ rtl/core/three_key_scanner_with_chords.sv @@
// Top level of the three-key scanner with chord detection.
//
//  channel   dir  payload                                   transfer
//  sample    in   key_pins                                  valid && ready
//  result    out  changed .. chord_event (9 fields)         valid && ready
//  cfg       in   cfg_index, cfg_data                       cfg_we
//
// One sample is taken per cycle while the sample side is ready; its result
// appears in the output register on the next cycle. Key state and the result
// register update together, in one pass through the step logic. The sample
// side is ready whenever the result register is empty or is being drained, so
// a stalled sink holds one result and stalls the source. Reset clears key
// state, the result valid flag and restores register defaults.
`default_nettype none

module three_key_scanner_with_chords
    import tksc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    tksc_sample_if.sink                 sample,
    tksc_result_if.source               result
);

    cfg_t       cfg_reg;
    key_state_t state_reg;
    key_state_t state_next;
    result_t    res_reg;
    result_t    res_next;
    logic       out_valid_reg;
    logic       take;

    assign sample.ready = !out_valid_reg || result.ready;
    assign take         = sample.valid && sample.ready;

    tksc_step u_step (
        .cfg      (cfg_reg),
        .cur      (state_reg),
        .key_pins (sample.key_pins),
        .nxt      (state_next),
        .res      (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.led_mode   <= LED_MODE_NONE;
            cfg_reg.full_level <= FULL_LEVEL_RST;
            cfg_reg.hold_limit <= HOLD_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_LED_MODE:   cfg_reg.led_mode   <= cfg_data[1:0];
                REG_FULL_LEVEL: cfg_reg.full_level <= cfg_data[LEVEL_W-1:0];
                REG_HOLD_LIMIT: cfg_reg.hold_limit <= cfg_data[HOLD_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload holds while stalled.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.changed      = res_reg.changed;
    assign result.pressed_mask = res_reg.pressed_mask;
    assign result.last_key     = res_reg.last_key;
    assign result.new_presses  = res_reg.new_presses;
    assign result.led0_cmd     = res_reg.led0_cmd;
    assign result.led0_level   = res_reg.led0_level;
    assign result.led1_cmd     = res_reg.led1_cmd;
    assign result.led1_level   = res_reg.led1_level;
    assign result.chord_event  = res_reg.chord_event;

endmodule

`default_nettype wire

@@ tb/three_key_scanner_with_chords_test.sv @@
// Self-checking testbench for the three-key scanner with chord detection.
`timescale 1ns / 100ps

module three_key_scanner_with_chords_test;
    import tksc_pkg::*;

    localparam int STALL_LIMIT    = 1000;
    localparam int HOLD_OFF_TICKS = 64;
    localparam int PHASE_SAMPLES  = 25;
    localparam int MAX_REPORTS    = 50;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    reg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tksc_sample_if smp ();
    tksc_result_if res ();

    three_key_scanner_with_chords dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (smp),
        .result    (res)
    );

    // Scanner image kept alongside the block
    logic [KEY_COUNT-1:0] key_held = '0;
    logic [HOLD_W-1:0]    hold_ticks [KEY_COUNT] = '{default: '0};
    logic [1:0]           recent_key = '0;
    logic [1:0]           mode_reg = LED_MODE_NONE;
    logic [LEVEL_W-1:0]   full_level_reg = FULL_LEVEL_RST;
    logic [HOLD_W-1:0]    hold_limit_reg = HOLD_LIMIT_RST;

    result_t expected_results [$];
    int      error_count = 0;
    int      samples_sent = 0;
    int      idle_cycles = 0;
    bit      tx_steady = 1'b0;
    bit      rx_steady = 1'b0;
    bit      rx_hold_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Advance the scanner image by one tick and return its result
    function automatic result_t scan_tick(logic [2:0] pins);
        result_t          r;
        logic             pressed;
        logic [1:0]       ev;
        logic [1:0]       led_cmd [2];
        logic [7:0]       led_lvl [2];
        int               k;
        r = '0;
        led_cmd = '{LED_CMD_NONE, LED_CMD_NONE};
        led_lvl = '{8'd0, 8'd0};
        for (k = 0; k < KEY_COUNT; k++)
        begin
            pressed = !pins[k];
            if (!key_held[k])
            begin
                if (pressed)
                begin
                    key_held[k] = 1'b1;
                    r.changed = 1'b1;
                    r.new_presses = r.new_presses + 2'd1;
                    recent_key = 2'(k);
                    if (k < 2)
                    begin
                        if (mode_reg == LED_MODE_OFTEN_ON)
                        begin
                            led_cmd[k] = LED_CMD_SET;
                            led_lvl[k] = 8'd0;
                        end
                        else if (mode_reg == LED_MODE_OFTEN_OFF)
                        begin
                            led_cmd[k] = LED_CMD_SET;
                            led_lvl[k] = full_level_reg;
                        end
                    end
                end
            end
            else if (!pressed)
            begin
                if (k < 2)
                begin
                    if (mode_reg == LED_MODE_OFTEN_ON)
                    begin
                        led_cmd[k] = LED_CMD_RAMP;
                        led_lvl[k] = full_level_reg;
                    end
                    else if (mode_reg == LED_MODE_OFTEN_OFF)
                    begin
                        led_cmd[k] = LED_CMD_RAMP;
                        led_lvl[k] = 8'd0;
                    end
                end
                key_held[k] = 1'b0;
                r.changed = 1'b1;
                hold_ticks[k] = '0;
            end
            else
            begin
                if (hold_ticks[k] < HOLD_CAP)
                    hold_ticks[k] = hold_ticks[k] + 1'b1;
                if (hold_ticks[k] > hold_limit_reg)
                begin
                    hold_ticks[k] = '0;
                    ev = CHORD_NONE;
                    if (k == 2 && key_held[0] && key_held[1] && recent_key == 2'd2)
                        ev = CHORD_KEY3_MODE;
                    else if (k == 0 && key_held[1] && key_held[2] && recent_key == 2'd0)
                        ev = CHORD_KEY12_MODE;
                    else if (k == 1 && key_held[0] && key_held[2] && recent_key == 2'd1)
                        ev = CHORD_BACKGROUND;
                    // first firing key in scan order wins
                    if (r.chord_event == CHORD_NONE)
                        r.chord_event = ev;
                end
            end
        end
        r.pressed_mask = key_held;
        r.last_key     = recent_key;
        r.led0_cmd     = led_cmd[0];
        r.led0_level   = led_lvl[0];
        r.led1_cmd     = led_cmd[1];
        r.led1_level   = led_lvl[1];
        return r;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            error_count++;
            // keep the log short on a badly broken build
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // Compare every result transfer with the oldest pending tick
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result transfer expected none, actual mask %0d chord %0d",
                         $time, res.pressed_mask, res.chord_event);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("changed",      want.changed,      res.changed);
                check_field("pressed_mask", want.pressed_mask, res.pressed_mask);
                check_field("last_key",     want.last_key,     res.last_key);
                check_field("new_presses",  want.new_presses,  res.new_presses);
                check_field("led0_cmd",     want.led0_cmd,     res.led0_cmd);
                check_field("led0_level",   want.led0_level,   res.led0_level);
                check_field("led1_cmd",     want.led1_cmd,     res.led1_cmd);
                check_field("led1_level",   want.led1_level,   res.led1_level);
                check_field("chord_event",  want.chord_event,  res.chord_event);
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (smp.valid && smp.ready) || (res.valid && res.ready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result sink: random stalls, plus a long hold-off on request
    initial
    begin
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                res.ready = 1'b0;
                repeat (HOLD_OFF_TICKS) @(negedge clk);
            end
            res.ready = rx_steady ? 1'b1 : ($urandom_range(99) >= 11);
        end
    end

    task automatic send_sample(logic [2:0] pins);
        bit accepted;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            if (!tx_steady && $urandom_range(99) < 11)
                smp.valid = 1'b0;
            else
            begin
                smp.valid = 1'b1;
                smp.key_pins = pins;
                @(posedge clk);
                while (!smp.ready)
                    @(posedge clk);
                accepted = 1'b1;
            end
        end
        expected_results.push_back(scan_tick(pins));
        samples_sent++;
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic drain();
        @(negedge clk);
        smp.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        case (idx)
            REG_LED_MODE:   mode_reg = value[1:0];
            REG_FULL_LEVEL: full_level_reg = value[LEVEL_W-1:0];
            REG_HOLD_LIMIT: hold_limit_reg = value[HOLD_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_config(logic [1:0] mode, logic [7:0] level, logic [9:0] limit);
        drain();
        write_reg(REG_LED_MODE, CFG_DATA_W'(mode));
        write_reg(REG_FULL_LEVEL, CFG_DATA_W'(level));
        write_reg(REG_HOLD_LIMIT, limit);
    endtask

    // Press all keys in random order, hold, then release
    task automatic run_chord_burst();
        int         order [3];
        int         j;
        int         pick;
        int         swap;
        int         span;
        logic [2:0] pins;
        order = '{0, 1, 2};
        for (j = 2; j > 0; j--)
        begin
            pick = $urandom_range(j);
            swap = order[j];
            order[j] = order[pick];
            order[pick] = swap;
        end
        pins = 3'b111;
        for (j = 0; j < 3; j++)
        begin
            pins[order[j]] = 1'b0;
            repeat ($urandom_range(1, 2)) send_sample(pins);
        end
        span = (hold_limit_reg > 20) ? 20 : int'(hold_limit_reg);
        repeat ($urandom_range(span + 3))
        begin
            // now and then bounce one key
            if ($urandom_range(99) < 5)
                send_sample(pins ^ (3'b001 << $urandom_range(2)));
            else
                send_sample(pins);
        end
        while (pins != 3'b111)
        begin
            pins = pins | (3'b001 << $urandom_range(2));
            send_sample(pins);
        end
    endtask

    task automatic send_noise(int count);
        repeat (count) send_sample(3'($urandom_range(7)));
    endtask

    task automatic test_reset_state();
        send_sample(3'b111);
        send_sample(3'b110);
        send_sample(3'b100);
        send_sample(3'b000);
        send_sample(3'b011);
        send_sample(3'b111);
    endtask

    task automatic test_led_commands();
        set_config(LED_MODE_OFTEN_ON, 8'd0, 10'd500);
        send_sample(3'b000);
        send_sample(3'b101);
        send_sample(3'b111);
        send_sample(3'b010);
        set_config(LED_MODE_OFTEN_OFF, 8'd255, 10'd500);
        send_sample(3'b000);
        send_sample(3'b111);
        send_sample(3'b110);
        send_sample(3'b001);
        set_config(2'd3, 8'hA5, 10'd500);
        send_sample(3'b000);
        send_sample(3'b111);
        set_config(LED_MODE_OFTEN_ON, 8'h5A, 10'd500);
        send_sample(3'b101);
        send_sample(3'b111);
    endtask

    // A zero limit checks the chord on every held tick
    task automatic test_zero_hold_limit();
        set_config(LED_MODE_OFTEN_OFF, 8'h3C, 10'd0);
        send_sample(3'b111);
        send_sample(3'b011);
        send_sample(3'b001);
        send_sample(3'b000);
        send_sample(3'b000);
        send_sample(3'b000);
        send_sample(3'b111);
    endtask

    // Counters cap at the hold ceiling; lowering the limit then fires at once
    task automatic test_saturated_hold();
        set_config(LED_MODE_NONE, 8'd255, 10'h3FF);
        send_sample(3'b111);
        send_sample(3'b110);
        send_sample(3'b100);
        send_sample(3'b000);
        repeat (int'(HOLD_CAP) + 5) send_sample(3'b000);
        set_config(LED_MODE_NONE, 8'd255, 10'd599);
        repeat (3) send_sample(3'b000);
        send_sample(3'b111);
    endtask

    task automatic test_backpressure();
        set_config(LED_MODE_OFTEN_ON, 8'd200, 10'd3);
        tx_steady = 1'b1;
        rx_hold_req = 1'b1;
        run_chord_burst();
        send_noise(40);
        run_chord_burst();
        tx_steady = 1'b0;
    endtask

    task automatic test_random_scan();
        int         phase;
        int         target;
        logic [7:0] level;
        logic [9:0] limit;
        for (phase = 0; phase < 8; phase++)
        begin
            level = (phase == 0) ? 8'd0 : (phase == 1) ? 8'd255 : 8'($urandom_range(255));
            if (phase == 2)
                limit = 10'd1;
            else if (phase == 7)
                limit = 10'd40;
            else
                limit = 10'($urandom_range(1, 12));
            set_config(2'(phase % 4), level, limit);
            tx_steady = (phase == 3);
            rx_steady = (phase == 3);
            target = samples_sent + PHASE_SAMPLES;
            while (samples_sent < target)
            begin
                if ($urandom_range(99) < 80)
                    run_chord_burst();
                else
                    send_noise($urandom_range(1, 6));
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_LED_MODE;
        cfg_data = '0;
        smp.valid = 1'b0;
        smp.key_pins = 3'b111;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_led_commands();
        test_zero_hold_limit();
        test_saturated_hold();
        test_backpressure();
        test_random_scan();

        drain();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
